>>> rtl/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on the rising edge of clk, held off during reset.
`define RPCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a condition that must hold on every rising edge of clk outside reset.
`define RPCD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

>>> rtl/rpcd_pkg.sv
// Types and constants for the parenthesized-count run-length decoder.
package rpcd_pkg;

	typedef logic [7:0] byte_t;

	// Window of four bytes, index 0 is the oldest.
	typedef logic [3:0][7:0] win_t;

	// Outcome of the pattern check on a full window.
	typedef struct packed {
		logic       hit;
		logic [3:0] count;
	} match_t;

	localparam byte_t      OPEN_MARK  = 8'h28;
	localparam byte_t      CLOSE_MARK = 8'h29;
	localparam byte_t      DIGIT_BASE = 8'h30;
	localparam logic [3:0] MAX_REPEAT = 4'd9;
	localparam logic [2:0] WIN_FULL   = 3'd4;

endpackage

>>> rtl/rpcd_in_if.sv
// Input channel: one compressed byte and its end-of-stream mark per transaction.
interface rpcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

>>> rtl/rpcd_out_if.sv
// Output channel: one decompressed byte and its end-of-stream mark per transaction.
interface rpcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> rtl/rle_paren_count_decoder_unit.sv
// A byte is accepted in ST_IDLE and checked in ST_CHECK; a literal is registered into the output then.
// No new input byte is taken until the last one is checked and the bytes it releases are emitted.
// A repeat "(d)c" holds the input while the repeat counter emits its d copies after its check.
// Output stalls hold the sequencer; the output register frees as its transaction completes.
// Reset: arst_n clears the window, its count, the sequencer state and the output valid at once.
`include "assert_macros.svh"

module rle_paren_count_decoder_unit (
	input logic       clk,
	input logic       arst_n,
	rpcd_in_if.sink   din,
	rpcd_out_if.source dout
);
	import rpcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REPEAT,
		ST_FLUSH
	} state_t;

	state_t     state_q;
	win_t       win_q;
	logic [2:0] n_q;
	logic       last_q;
	logic [3:0] rep_q;
	logic       out_valid_q;
	byte_t      out_byte_q;
	logic       out_last_q;
	match_t     match;
	logic       slot_free;
	logic       out_load;

	// Check the window
	rpcd_match u_match (
		.win    (win_q),
		.result (match)
	);

	// Output register is free when empty or when its transaction completes now
	assign slot_free = !out_valid_q || dout.ready;

	// The sequencer loads a new output byte this cycle
	assign out_load = slot_free &&
		(((state_q == ST_CHECK) && (n_q == WIN_FULL) && !match.hit) ||
		(state_q == ST_REPEAT) || (state_q == ST_FLUSH));

	assign din.ready     = (state_q == ST_IDLE);
	assign dout.valid    = out_valid_q;
	assign dout.out_byte = out_byte_q;
	assign dout.out_last = out_last_q;

	// Sequencer: load the window, check it, then emit repeats or literals one a cycle while the output is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= '0;
			n_q         <= '0;
			last_q      <= 1'b0;
			rep_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			// Drop the output once its transaction completes and nothing replaces it
			if (out_valid_q && dout.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					// Append the new byte behind the pending ones
					if (din.valid) begin
						win_q[n_q[1:0]] <= din.in_byte;
						n_q             <= n_q + 3'd1;
						last_q          <= din.in_last;
						state_q         <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (n_q == WIN_FULL) begin
						if (match.hit) begin
							rep_q   <= match.count;
							state_q <= ST_REPEAT;
						end else if (slot_free) begin
							// Emit the oldest byte as a literal and advance the window
							out_valid_q <= 1'b1;
							out_byte_q  <= win_q[0];
							out_last_q  <= 1'b0;
							win_q[0]    <= win_q[1];
							win_q[1]    <= win_q[2];
							win_q[2]    <= win_q[3];
							n_q         <= 3'd3;
							state_q     <= last_q ? ST_FLUSH : ST_IDLE;
						end
					end else begin
						state_q <= last_q ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_REPEAT: begin
					// Emit the repeated byte, count down, empty the window on the final one
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= win_q[3];
						out_last_q  <= last_q && (rep_q == 4'd1);
						rep_q       <= rep_q - 4'd1;
						if (rep_q == 4'd1) begin
							n_q     <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					// Drain the window as literals, marking the final byte
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= win_q[0];
						out_last_q  <= (n_q == 3'd1);
						win_q[0]    <= win_q[1];
						win_q[1]    <= win_q[2];
						win_q[2]    <= win_q[3];
						n_q         <= n_q - 3'd1;
						if (n_q == 3'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RPCD_ASSERT_ALWAYS(a_rep_range, rep_q <= MAX_REPEAT, "repeat count out of range")
	`RPCD_ASSERT(a_idle_window, (state_q == ST_IDLE) |-> (n_q <= 3'd3), "window full while idle")
	`RPCD_ASSERT(a_accept_check, (din.valid && din.ready) |=> (state_q == ST_CHECK), "no check")
	`RPCD_ASSERT(a_repeat_nonzero, (state_q == ST_REPEAT) |-> (rep_q != 4'd0), "repeat with zero count")
	`RPCD_ASSERT(a_flush_nonempty, (state_q == ST_FLUSH) |-> (n_q != 3'd0), "flush of an empty window")

endmodule

>>> rtl/rpcd_match.sv
// Pattern check of a full window: open mark, digit one to nine, close mark, non-zero byte.
module rpcd_match (
	input  rpcd_pkg::win_t   win,
	output rpcd_pkg::match_t result
);
	import rpcd_pkg::*;

	logic digit_ok;

	// Accept only the digits one through nine
	assign digit_ok = (win[1] > DIGIT_BASE) && (win[1] <= (DIGIT_BASE + byte_t'(MAX_REPEAT)));

	assign result.hit = (win[0] == OPEN_MARK) && digit_ok &&
		(win[2] == CLOSE_MARK) && (win[3] != 8'h00);

	// Low nibble of an ASCII digit is its value
	assign result.count = win[1][3:0];
endmodule

>>> tb/rpcd_stream_checker.sv
// Stream checker for the parenthesized-count decoder: predicts and compares every output byte.
`timescale 1ns / 1ps

module rpcd_stream_checker (
	input  logic        clk,
	input  logic        arst_n,
	rpcd_in_if          din,
	rpcd_out_if         dout,
	output int unsigned errors,
	output int unsigned pending_results
);
	import rpcd_pkg::*;

	typedef struct packed {
		byte_t data;
		logic  last;
	} out_beat_t;

	// Predicted output bytes, oldest first
	out_beat_t expected_q[$];
	out_beat_t head;

	// Shadow of the decode window: up to three held bytes, oldest first
	byte_t     window [3];
	int        window_fill;

	initial errors = 0;

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	// Append one compressed byte to the window and queue the bytes it releases
	task automatic expand_byte(input byte_t b, input logic fin);
		byte_t w [4];
		byte_t emit [9];
		int    n;
		int    k;
		int    digit;
		logic  hit;
		n = window_fill;
		k = 0;
		for (int i = 0; i < n; i++)
			w[i] = window[i];
		w[n] = b;
		n++;

		// Check a full window for "(d)c" with d in 1..9 and c non-zero
		if (n == 4) begin
			digit = int'(w[1]) - int'(DIGIT_BASE);
			hit = (w[0] == OPEN_MARK) && (digit >= 1) && (digit <= int'(MAX_REPEAT)) &&
				(w[2] == CLOSE_MARK) && (w[3] != 8'h00);
			if (hit) begin
				for (int i = 0; i < digit; i++)
					emit[k++] = w[3];
				n = 0;
			end else begin
				emit[k++] = w[0];
				w[0] = w[1];
				w[1] = w[2];
				w[2] = w[3];
				n = 3;
			end
		end

		// Flush what is left as literals at the end of a stream
		if (fin) begin
			for (int i = 0; i < n; i++)
				emit[k++] = w[i];
			n = 0;
		end

		for (int j = 0; j < k; j++)
			expected_q.push_back('{data: emit[j], last: fin && (j == k - 1)});
		for (int i = 0; i < n; i++)
			window[i] = w[i];
		window_fill = n;
	endtask

	// Track accepted inputs and compare accepted outputs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			window_fill = 0;
			pending_results = 0;
		end else begin
			if (din.valid && din.ready)
				expand_byte(din.in_byte, din.in_last);
			if (dout.valid && dout.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected out_byte", dout.out_byte, 0);
				end else begin
					head = expected_q.pop_front();
					if (dout.out_byte !== head.data)
						report_mismatch("out_byte", dout.out_byte, head.data);
					if (dout.out_last !== head.last)
						report_mismatch("out_last", dout.out_last, head.last);
				end
			end
			pending_results = expected_q.size();
		end
	end

endmodule

>>> tb/rle_paren_count_decoder_unit_tb.sv
// Top of the decoder testbench: clock, reset, stream stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module rle_paren_count_decoder_unit_tb;
	import rpcd_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 250;
	localparam int unsigned MAX_IDLE      = 12;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned mismatches;
	int unsigned results_due;
	int unsigned items_sent;
	int unsigned cycle_count;
	int unsigned tx_max_gap;
	int unsigned rx_max_stall;
	logic        rx_hold_req;
	byte_t       stream_q[$];

	rpcd_in_if  din_ch ();
	rpcd_out_if dout_ch ();

	rle_paren_count_decoder_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	rpcd_stream_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.din             (din_ch),
		.dout            (dout_ch),
		.errors          (mismatches),
		.pending_results (results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one byte after a random gap and hold it until the transaction completes
	task automatic send_item(input byte_t b, input logic fin);
		int unsigned gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap != 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din_ch.valid   <= 1'b1;
		din_ch.in_byte <= b;
		din_ch.in_last <= fin;
		@(posedge clk);
		while (!din_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Send the queued stream, marking its final byte
	task automatic send_stream();
		for (int i = 0; i < stream_q.size(); i++)
			send_item(stream_q[i], i == stream_q.size() - 1);
		stream_q.delete();
	endtask

	// Stop offering and wait until every predicted byte has come out
	task automatic drain_results();
		din_ch.valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Build a stream of well-formed repeats (half the tokens), some broken ones and loose literals
	task automatic build_random_stream();
		int unsigned tokens;
		byte_t       digit_ch;
		byte_t       close_ch;
		byte_t       rep_char;
		tokens = $urandom_range(1, 6);
		repeat (tokens) begin
			digit_ch = DIGIT_BASE + byte_t'($urandom_range(1, 9));
			close_ch = CLOSE_MARK;
			rep_char = byte_t'($urandom_range(1, 255));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					stream_q.push_back(OPEN_MARK);
					stream_q.push_back(digit_ch);
					stream_q.push_back(close_ch);
					stream_q.push_back(rep_char);
				end
				5: begin
					case ($urandom_range(0, 3))
						0: rep_char = 8'h00;
						1: digit_ch = DIGIT_BASE;
						2: digit_ch = byte_t'($urandom_range(0, 255));
						default: close_ch = byte_t'($urandom_range(0, 255));
					endcase
					stream_q.push_back(OPEN_MARK);
					stream_q.push_back(digit_ch);
					stream_q.push_back(close_ch);
					stream_q.push_back(rep_char);
				end
				6: stream_q.push_back(OPEN_MARK);
				default: stream_q.push_back(byte_t'($urandom_range(0, 255)));
			endcase
		end
	endtask

	// End the run if it stalls
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("rle_paren_count_decoder_unit regression: fail");
		$finish;
	end

	// Drain results with random stalls; take a long hold-off when asked
	initial begin
		int unsigned stall;
		dout_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				stall = LONG_HOLD;
				rx_hold_req = 1'b0;
			end else begin
				stall = $urandom_range(0, rx_max_stall);
			end
			if (stall != 0) begin
				dout_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			dout_ch.ready <= 1'b1;
			@(posedge clk);
			while (!(dout_ch.valid && dout_ch.ready))
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		int unsigned phase_no;
		int unsigned random_start;
		arst_n         = 1'b0;
		din_ch.valid   = 1'b0;
		din_ch.in_byte = 8'h00;
		din_ch.in_last = 1'b0;
		rx_hold_req    = 1'b0;
		tx_max_gap     = 0;
		rx_max_stall   = 0;
		items_sent     = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: short windows, digit one and nine, zero repeat char, digit zero, non-digit
		stream_q = '{8'h41};
		send_stream();
		stream_q = '{8'h00, 8'hFF};
		send_stream();
		stream_q = '{OPEN_MARK, DIGIT_BASE + 8'd1, CLOSE_MARK, 8'hFF};
		send_stream();
		stream_q = '{OPEN_MARK, DIGIT_BASE + 8'd9, CLOSE_MARK, 8'h01};
		send_stream();
		stream_q = '{OPEN_MARK, DIGIT_BASE + 8'd3, CLOSE_MARK, 8'h00};
		send_stream();
		stream_q = '{OPEN_MARK, DIGIT_BASE, CLOSE_MARK, 8'h61};
		send_stream();
		stream_q = '{OPEN_MARK, DIGIT_BASE + 8'd10, CLOSE_MARK, 8'h62};
		send_stream();
		drain_results();

		// Random streams, cycling the idle pattern on both sides
		phase_no = 0;
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			case (phase_no % 4)
				0: begin
					tx_max_gap   = MAX_IDLE;
					rx_max_stall = MAX_IDLE;
				end
				1: begin
					tx_max_gap   = 0;
					rx_max_stall = 0;
				end
				2: begin
					tx_max_gap   = MAX_IDLE;
					rx_max_stall = 0;
				end
				default: begin
					tx_max_gap   = 0;
					rx_max_stall = MAX_IDLE;
				end
			endcase
			// Back up the block behind a long output hold-off
			if (phase_no == 5) begin
				tx_max_gap  = 0;
				rx_hold_req = 1'b1;
			end
			// Pause the sender until the output side is empty
			if (phase_no == 9)
				drain_results();
			build_random_stream();
			send_stream();
			phase_no++;
		end

		drain_results();
		if (mismatches == 0)
			$display("rle_paren_count_decoder_unit regression: pass");
		else
			$display("rle_paren_count_decoder_unit regression: fail");
		$finish;
	end

endmodule
